// ----- hdl/mcqs_pkg.sv -----
// Shared types, constants and the Gray-step decode for the quadrature spinner.
// Used by mcqs_chan and multi_channel_quadrature_spinner.
`timescale 1ns / 1ps

package mcqs_pkg;

  localparam int unsigned PinsW = 2;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StepW = 7;

  localparam logic [StepW-1:0] StepReset   = 7'd2;
  localparam logic [PosW-1:0]  CentreReset = 8'h80;
  localparam logic [PosW-1:0]  PosTop      = 8'hFF;

  typedef enum logic [0:0] {
    CfgStep   = 1'b0,
    CfgCentre = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirFwd  = 2'd1,
    DirBwd  = 2'd2
  } dir_e;

  typedef struct packed {
    logic sample;
    logic report;
  } spin_ctrl_t;

  function automatic dir_e decode_step(input logic [PinsW-1:0] now_pins,
                                       input logic [PinsW-1:0] old_pins);
    logic [2*PinsW-1:0] code;
    dir_e               dir;
    code = {now_pins, old_pins};
    case (code) inside
      4'h1, 4'h7, 4'hE, 4'h8: dir = DirFwd;
      4'h4, 4'h2, 4'hB, 4'hD: dir = DirBwd;
      default:                dir = DirNone;
    endcase
    return dir;
  endfunction

endpackage

// ----- hdl/mcqs_chan.sv -----
// One spinner channel: previous pin pair, position register, limit check.
// Depends on mcqs_pkg.
`timescale 1ns / 1ps

module mcqs_chan
  import mcqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spin_ctrl_t       ctrl_i,
  input  logic [PinsW-1:0] pins_i,
  input  logic [StepW-1:0] step_i,
  input  logic [PosW-1:0]  centre_i,
  output logic [PosW-1:0]  pos_o,
  output logic             over_o
);

  logic [PinsW-1:0] prev_q, prev_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  step_ext;
  logic [PosW-1:0]  upper;
  dir_e             dir;

  assign step_ext = {1'b0, step_i};
  assign upper    = PosTop - step_ext;
  assign dir      = decode_step(pins_i, prev_q);

  always_comb begin
    prev_d = prev_q;
    pos_d  = pos_q;
    if (ctrl_i.report) begin
      pos_d = centre_i;
    end else if (ctrl_i.sample) begin
      prev_d = pins_i;
      case (dir)
        DirFwd:  if (pos_q < upper) pos_d = pos_q + step_ext;
        DirBwd:  if (pos_q > step_ext) pos_d = pos_q - step_ext;
        default: pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= CentreReset;
    end else begin
      prev_q <= prev_d;
      pos_q  <= pos_d;
    end
  end

  assign pos_o  = pos_q;
  assign over_o = (pos_q >= upper) || (pos_q <= step_ext);

endmodule

// ----- hdl/multi_channel_quadrature_spinner.sv -----
// Top level of the multi-channel quadrature spinner decoder.
// Depends on mcqs_pkg and mcqs_chan.
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tdata pins, tuser command
// m_axis    out        m_axis_tvalid/tready        tdata positions, tuser overspin
// cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One request per cycle while no report is stalled; each request passes the input register.
// A report reaches m_axis through the output register, in the cycle after it leaves.
// Reset clears control state, step to 2, centre to 128, positions to 128.
// A stalled report holds the input register; no sample passes meanwhile, since
// the input register is not free.
`timescale 1ns / 1ps

module multi_channel_quadrature_spinner
  import mcqs_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pins_chan0, pins_chan1, ... (2 bits each), zero fill
  input  logic [((PinsW*NUM_CHANNELS+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // position_chan0, position_chan1, ... (8 bits each)
  output logic [PosW*NUM_CHANNELS-1:0]        m_axis_tdata,
  // overspin
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [PosW-1:0]                     cfg_data_i
);

  logic                            in_valid_q;
  logic                            cmd_q;
  logic [PinsW*NUM_CHANNELS-1:0]   pins_q;
  logic                            adv;
  logic                            in_take;
  logic [StepW-1:0]                step_q;
  logic [PosW-1:0]                 centre_q;
  spin_ctrl_t                      ctrl;
  logic [PosW-1:0]                 pos [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]         over;
  logic                            out_valid_q;
  logic [PosW*NUM_CHANNELS-1:0]    out_pos_q;
  logic                            out_over_q;
  cfg_reg_e                        cfg_sel;

  assign adv           = in_valid_q && (!cmd_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign ctrl.sample   = adv && !cmd_q;
  assign ctrl.report   = adv && cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= s_axis_tuser;
      pins_q <= s_axis_tdata[PinsW*NUM_CHANNELS-1:0];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= StepReset;
      centre_q <= CentreReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_sel)
        CfgStep:   step_q   <= cfg_data_i[StepW-1:0];
        CfgCentre: centre_q <= cfg_data_i;
        default:   centre_q <= centre_q;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    mcqs_chan u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pins_i   (pins_q[g*PinsW +: PinsW]),
      .step_i   (step_q),
      .centre_i (centre_q),
      .pos_o    (pos[g]),
      .over_o   (over[g])
    );

    always_ff @(posedge clk_i) begin
      if (ctrl.report) out_pos_q[g*PosW +: PosW] <= pos[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.report) out_over_q <= |over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.report) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pos_q;
  assign m_axis_tuser  = out_over_q;

`ifndef SYNTHESIS
  a_rise_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.report))
    else $error("result appeared without a report");

  a_recentre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.report |=> (pos[0] == $past(centre_q)))
    else $error("position not recentred after report");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && cmd_q && out_valid_q))
    else $error("input stalled without a pending report");
`endif

endmodule
